>>> rtl/core/gbns_pkg.sv
`timescale 1ns / 1ps

package gbns_pkg;

  // Default sizing
  localparam int WINDOW_MAX_DEF = 16;
  localparam int SEQ_BITS_DEF   = 16;
  localparam int DATA_BITS_DEF  = 32;

  // Config register widths and reset values
  localparam int WS_BITS       = 5;
  localparam int TO_BITS       = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [WS_BITS-1:0] WS_RESET = 5'd4;
  localparam logic [TO_BITS-1:0] TO_RESET = 16'd100;

  // Config register indexes
  localparam logic CFG_IDX_WINDOW  = 1'b0;
  localparam logic CFG_IDX_TIMEOUT = 1'b1;

  // Request commands
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result events
  localparam logic [2:0] EV_TX_NEW   = 3'd0;
  localparam logic [2:0] EV_REFUSED  = 3'd1;
  localparam logic [2:0] EV_RETX     = 3'd2;
  localparam logic [2:0] EV_ACK_OK   = 3'd3;
  localparam logic [2:0] EV_ACK_BAD  = 3'd4;
  localparam logic [2:0] EV_IGNORED  = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } st_t;

  // Result queue status toward the control logic
  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } oq_stat_t;

endpackage

>>> rtl/core/gbns_ram.sv
`timescale 1ns / 1ps

module gbns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/core/gbns_out_q.sv
`timescale 1ns / 1ps

// Two-deep result queue; decouples result stall from request intake.
module gbns_out_q
  import gbns_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  output oq_stat_t         stat
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slot_r[rd_ptr_r];
  assign stat.cnt  = cnt_r;
  assign stat.pop  = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/go_back_n_sender_window_unit.sv
`timescale 1ns / 1ps

// Go-Back-N sender window. Requests on in_* are send (payload), ack (cumulative
// sequence number plus checksum flag) or timer tick; each yields one result on
// out_*, except a stale ack or a timer expiry with a non-empty window, which
// retransmits every held packet in order, one result each, tlast on the final.
// Sequence numbers start at 1, wrap at SEQ_BITS and compare in serial order.
// Payloads sit in a WINDOW_MAX-entry ring RAM (one write, one registered read).
// Flow: requests with one result each can follow
// back to back while the two-deep result queue has room. A retransmit of N
// packets walks the RAM read port one entry per cycle while the result queue
// has room, so input stays closed until the last entry's read data is queued.
// Config writes (cfg_we) are meant for idle periods only.
module go_back_n_sender_window_unit
  import gbns_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic in_tvalid,
  output logic in_tready,
  // payload, ack_number, checksum_ok (LSB first), zero pad to bytes
  input  logic [((DATA_BITS + SEQ_BITS + 1 + 7) / 8) * 8 - 1:0] in_tdata,
  // command
  input  logic [1:0] in_tuser,

  output logic out_tvalid,
  input  logic out_tready,
  // seq_number, data_out, window_count, window_full (LSB first), zero pad
  output logic [((SEQ_BITS + DATA_BITS + $clog2(WINDOW_MAX + 1) + 1 + 7) / 8) * 8 - 1:0]
               out_tdata,
  // event_res
  output logic [2:0] out_tuser,
  output logic       out_tlast,

  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CW  = $clog2(WINDOW_MAX + 1);            // entry count width
  localparam int IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;  // ring index
  localparam int EW  = (CW > WS_BITS) ? CW : WS_BITS;     // window compare width
  localparam int FW  = (SEQ_BITS > CW) ? SEQ_BITS : CW;   // free-count compare
  localparam int RW  = SEQ_BITS + DATA_BITS + CW + 1;     // tdata fields
  localparam int OTW = ((RW + 7) / 8) * 8;
  localparam int QW  = RW + 3 + 1;                        // + event + last

  // Request fields
  logic [DATA_BITS-1:0] in_payload;
  logic [SEQ_BITS-1:0]  in_ack;
  logic                 in_cs;

  assign in_payload = in_tdata[DATA_BITS-1:0];
  assign in_ack     = in_tdata[DATA_BITS +: SEQ_BITS];
  assign in_cs      = in_tdata[DATA_BITS + SEQ_BITS];

  // Config
  logic [WS_BITS-1:0] window_size_r;
  logic [TO_BITS-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
      timeout_r     <= TO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WINDOW:  window_size_r <= cfg_data[WS_BITS-1:0];
        CFG_IDX_TIMEOUT: timeout_r     <= cfg_data[TO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window state
  st_t                 st_r, st_nxt;
  logic [IW-1:0]       head_idx_r, head_idx_nxt;
  logic [IW-1:0]       tail_idx_r, tail_idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SEQ_BITS-1:0] head_seq_r, head_seq_nxt;
  logic [SEQ_BITS-1:0] last_seq_r, last_seq_nxt;
  logic [TO_BITS-1:0]  timer_left_r, timer_left_nxt;
  logic                timer_run_r, timer_run_nxt;

  // Retransmit walk
  logic [IW-1:0]       walk_idx_r, walk_idx_nxt;
  logic [SEQ_BITS-1:0] walk_seq_r, walk_seq_nxt;
  logic [CW-1:0]       walk_left_r, walk_left_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SEQ_BITS-1:0] rd_seq_r, rd_seq_nxt;
  logic                rd_last_r, rd_last_nxt;

  logic                 accept;
  logic                 walk_start;
  logic                 rd_issue;
  logic                 ram_we;
  logic [DATA_BITS-1:0] ram_rdata;

  oq_stat_t             q_stat;
  logic                 q_push;
  logic [QW-1:0]        q_push_data;
  logic [QW-1:0]        q_data;

  assign accept = in_tvalid && in_tready;

  // Effective window: 0 acts as 1, clamp to WINDOW_MAX
  logic [EW-1:0] ws_ext;
  logic [EW-1:0] eff_win;
  logic          cur_full;
  logic          single_full;

  assign ws_ext = EW'(window_size_r);

  always_comb begin
    if (ws_ext == '0) begin
      eff_win = EW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      eff_win = EW'(WINDOW_MAX);
    end else begin
      eff_win = ws_ext;
    end
  end

  assign cur_full    = (EW'(count_r) >= eff_win);
  assign single_full = (EW'(count_nxt) >= eff_win);

  // Ack decode: serial distance both ways
  logic [SEQ_BITS-1:0] ack_dist;   // ack - head
  logic [SEQ_BITS-1:0] back_dist;  // head - ack
  logic                stale;
  logic [CW-1:0]       free_cnt;
  logic [CW:0]         head_sum;
  logic [IW-1:0]       head_adv;

  assign ack_dist  = in_ack - head_seq_r;
  assign back_dist = head_seq_r - in_ack;
  assign stale     = (count_r != '0) && (back_dist != '0) && !back_dist[SEQ_BITS-1];

  // Entries freed: head..ack, capped at the window fill
  always_comb begin
    if (ack_dist[SEQ_BITS-1]) begin
      free_cnt = '0;
    end else if (FW'(ack_dist) >= FW'(count_r)) begin
      free_cnt = count_r;
    end else begin
      free_cnt = CW'(FW'(ack_dist) + FW'(1));
    end
  end

  always_comb begin
    head_sum = (CW + 1)'(head_idx_r) + (CW + 1)'(free_cnt);
    if (head_sum >= (CW + 1)'(WINDOW_MAX)) begin
      head_sum = head_sum - (CW + 1)'(WINDOW_MAX);
    end
    head_adv = IW'(head_sum);
  end

  logic [IW-1:0] tail_inc;
  logic [IW-1:0] walk_inc;

  assign tail_inc = (tail_idx_r == IW'(WINDOW_MAX - 1)) ? '0 : tail_idx_r + IW'(1);
  assign walk_inc = (walk_idx_r == IW'(WINDOW_MAX - 1)) ? '0 : walk_idx_r + IW'(1);

  // Single-result fields
  logic [2:0]           single_ev;
  logic [SEQ_BITS-1:0]  single_seq;
  logic [DATA_BITS-1:0] single_data;

  always_comb begin
    head_idx_nxt   = head_idx_r;
    tail_idx_nxt   = tail_idx_r;
    count_nxt      = count_r;
    head_seq_nxt   = head_seq_r;
    last_seq_nxt   = last_seq_r;
    timer_left_nxt = timer_left_r;
    timer_run_nxt  = timer_run_r;
    walk_start     = 1'b0;
    ram_we         = 1'b0;
    single_ev      = EV_IGNORED;
    single_seq     = '0;
    single_data    = '0;

    if (accept) begin
      case (in_tuser)
        CMD_SEND: begin
          if (cur_full) begin
            single_ev = EV_REFUSED;
          end else begin
            ram_we         = 1'b1;
            last_seq_nxt   = last_seq_r + SEQ_BITS'(1);
            count_nxt      = count_r + CW'(1);
            tail_idx_nxt   = tail_inc;
            timer_left_nxt = timeout_r;
            timer_run_nxt  = 1'b1;
            single_ev      = EV_TX_NEW;
            single_seq     = last_seq_r + SEQ_BITS'(1);
            single_data    = in_payload;
          end
        end
        CMD_ACK: begin
          if (!in_cs) begin
            single_ev = EV_ACK_BAD;
          end else if (stale) begin
            walk_start = 1'b1;
          end else begin
            head_idx_nxt = head_adv;
            head_seq_nxt = head_seq_r + SEQ_BITS'(free_cnt);
            count_nxt    = count_r - free_cnt;
            single_ev    = EV_ACK_OK;
          end
        end
        CMD_TICK: begin
          if (timer_run_r) begin
            if (timer_left_r > TO_BITS'(1)) begin
              timer_left_nxt = timer_left_r - TO_BITS'(1);
            end else if (count_r != '0) begin
              // expiry: restart and resend the window
              timer_left_nxt = timeout_r;
              walk_start     = 1'b1;
            end else begin
              timer_left_nxt = '0;
              timer_run_nxt  = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Walk counters and read pipeline
  always_comb begin
    walk_idx_nxt  = walk_idx_r;
    walk_seq_nxt  = walk_seq_r;
    walk_left_nxt = walk_left_r;
    if (walk_start) begin
      walk_idx_nxt  = head_idx_r;
      walk_seq_nxt  = head_seq_r;
      walk_left_nxt = count_r;
    end else if (rd_issue) begin
      walk_idx_nxt  = walk_inc;
      walk_seq_nxt  = walk_seq_r + SEQ_BITS'(1);
      walk_left_nxt = walk_left_r - CW'(1);
    end
    rd_vld_nxt  = rd_issue;
    rd_seq_nxt  = walk_seq_r;
    rd_last_nxt = (walk_left_r == CW'(1));
  end

  // FSM: next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (walk_start) begin
          st_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_issue && (walk_left_r == CW'(1))) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // FSM: outputs. A read is issued only when the queue can absorb its data.
  logic [2:0] q_used;
  assign q_used = {1'b0, q_stat.cnt} + 3'(rd_vld_r) - 3'(q_stat.pop);

  always_comb begin
    in_tready = 1'b0;
    rd_issue  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = !rd_vld_r && ((q_stat.cnt != 2'd2) || q_stat.pop);
      end
      ST_WALK: begin
        rd_issue = (q_used < 3'd2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      head_idx_r   <= '0;
      tail_idx_r   <= '0;
      count_r      <= '0;
      head_seq_r   <= SEQ_BITS'(1);
      last_seq_r   <= '0;
      timer_left_r <= '0;
      timer_run_r  <= 1'b0;
      walk_left_r  <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      head_idx_r   <= head_idx_nxt;
      tail_idx_r   <= tail_idx_nxt;
      count_r      <= count_nxt;
      head_seq_r   <= head_seq_nxt;
      last_seq_r   <= last_seq_nxt;
      timer_left_r <= timer_left_nxt;
      timer_run_r  <= timer_run_nxt;
      walk_left_r  <= walk_left_nxt;
      rd_vld_r     <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    walk_seq_r <= walk_seq_nxt;
    rd_seq_r   <= rd_seq_nxt;
    rd_last_r  <= rd_last_nxt;
  end

  // Payload ring
  gbns_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx_r),
    .wdata (in_payload),
    .re    (rd_issue),
    .raddr (walk_idx_r),
    .rdata (ram_rdata)
  );

  // Result push: walk data and single results never coincide
  assign q_push = (accept && !walk_start) || rd_vld_r;

  always_comb begin
    if (rd_vld_r) begin
      q_push_data = {rd_last_r, EV_RETX, cur_full, count_r, ram_rdata, rd_seq_r};
    end else begin
      q_push_data = {1'b1, single_ev, single_full, count_nxt, single_data, single_seq};
    end
  end

  gbns_out_q #(
    .WIDTH (QW)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (q_data),
    .stat      (q_stat)
  );

  assign out_tdata = OTW'(q_data[RW-1:0]);
  assign out_tuser = q_data[RW +: 3];
  assign out_tlast = q_data[QW-1];

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Checks the Go-Back-N sender window unit.
// A scoreboard keeps its own copy of the window (ring, head, count, sequence
// numbers, timer and the two registers) and turns each accepted request into
// the results it must cause. Each result the block hands out is compared
// field by field with the oldest one still pending.
// Stimulus: a short directed table, then random phases under several
// window and timeout settings.
module testbench;
  import gbns_pkg::*;

  localparam int WMAX  = WINDOW_MAX_DEF;
  localparam int IN_W  = ((DATA_BITS_DEF + SEQ_BITS_DEF + 1 + 7) / 8) * 8;
  localparam int OUT_W = ((SEQ_BITS_DEF + DATA_BITS_DEF + $clog2(WMAX + 1) + 1 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int PHASE_REQS = 16;
  // The 2-bit command field has one code the block does not define.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One result as it leaves the block.
  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] seq;
    logic [31:0] data;
    logic [4:0]  cnt;
    logic        full;
    logic        last;
  } sender_result_t;

  // Typed expectation riding along with a request, if any.
  typedef struct {
    bit             pinned;
    sender_result_t res;
  } pin_info_t;

  // One line of the directed table: either a request or a register update.
  typedef struct {
    bit             is_cfg;
    logic [15:0]    ws_val;
    logic [15:0]    to_val;
    logic [1:0]     cmd;
    logic [31:0]    pay;
    logic [15:0]    ack;
    logic           ok;
    bit             pinned;
    sender_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0]      in_tuser = CMD_SEND;

  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0]       out_tuser;
  logic             out_tlast;

  logic                     cfg_we = 1'b0;
  logic                     cfg_index = CFG_IDX_WINDOW;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  go_back_n_sender_window_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // payload, ack_number, checksum_ok, pad
    .in_tuser  (in_tuser),   // command
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // seq_number, data_out, window_count, window_full, pad
    .out_tuser (out_tuser),  // event_res
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Window model: mirrors the block's state after reset
  // ---------------------------------------------------------------
  logic [31:0] win_ring [WMAX];
  int unsigned win_head_idx = 0;
  int unsigned win_count = 0;
  logic [15:0] win_head_seq = 16'd1;   // oldest held, or next to send when empty
  logic [15:0] win_last_seq = 16'd0;   // last number handed out
  logic [15:0] win_timer_left = 16'd0;
  bit          win_timer_on = 1'b0;
  logic [4:0]  win_size_reg = WS_RESET;
  logic [15:0] win_timeout_reg = TO_RESET;

  sender_result_t pending_results[$];
  pin_info_t      pinned_q[$];
  stim_row_t      directed_rows[$];

  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;   // no idling and no stalls in the closing phase

  int unsigned phase_ws [PHASES] = '{4, 16, 1, 31, 17, 8};
  int unsigned phase_to [PHASES] = '{3, 8, 1, 0, 65535, 2};

  // Out-of-range window sizes clamp to 1..WMAX.
  function automatic int unsigned eff_window();
    if (win_size_reg == 0) return 1;
    if (win_size_reg > WMAX) return WMAX;
    return win_size_reg;
  endfunction

  // Serial arithmetic: a older than b.
  function automatic bit seq_older(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return (d != 16'd0) && (d < 16'h8000);
  endfunction

  function automatic void push_result(logic [2:0] ev, logic [15:0] seq,
                                      logic [31:0] data, logic last);
    sender_result_t r;
    r.ev = ev;
    r.seq = seq;
    r.data = data;
    r.cnt = 5'(win_count);
    r.full = (win_count >= eff_window());
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Go-back-N: replay every held packet, oldest first.
  function automatic void resend_window();
    int unsigned i;
    for (i = 0; i < win_count; i++)
      push_result(EV_RETX, win_head_seq + 16'(i), win_ring[(win_head_idx + i) % WMAX],
                  i == win_count - 1);
  endfunction

  function automatic void apply_request(logic [1:0] cmd, logic [31:0] pay,
                                        logic [15:0] ack, logic ok);
    if (cmd == CMD_SEND) begin
      if (win_count >= eff_window()) begin
        push_result(EV_REFUSED, 16'd0, 32'd0, 1'b1);
      end else begin
        win_last_seq = win_last_seq + 16'd1;
        win_ring[(win_head_idx + win_count) % WMAX] = pay;
        win_count++;
        win_timer_left = win_timeout_reg;
        win_timer_on = 1'b1;
        push_result(EV_TX_NEW, win_last_seq, pay, 1'b1);
      end
    end else if (cmd == CMD_ACK) begin
      if (!ok) begin
        push_result(EV_ACK_BAD, 16'd0, 32'd0, 1'b1);
      end else if (win_count > 0 && seq_older(ack, win_head_seq)) begin
        resend_window();
      end else begin
        // cumulative: free everything up to and including ack
        while (win_count > 0 && (seq_older(win_head_seq, ack) || win_head_seq == ack)) begin
          win_head_idx = (win_head_idx + 1) % WMAX;
          win_head_seq = win_head_seq + 16'd1;
          win_count--;
        end
        push_result(EV_ACK_OK, 16'd0, 32'd0, 1'b1);
      end
    end else if (cmd == CMD_TICK && win_timer_on) begin
      if (win_timer_left > 16'd1) begin
        win_timer_left = win_timer_left - 16'd1;
        push_result(EV_IGNORED, 16'd0, 32'd0, 1'b1);
      end else begin
        // expiry; timer rearms only if something is still held
        win_timer_on = 1'b0;
        win_timer_left = 16'd0;
        if (win_count > 0) begin
          win_timer_left = win_timeout_reg;
          win_timer_on = 1'b1;
          resend_window();
        end else begin
          push_result(EV_IGNORED, 16'd0, 32'd0, 1'b1);
        end
      end
    end else begin
      // tick with timer stopped, or the undefined command
      push_result(EV_IGNORED, 16'd0, 32'd0, 1'b1);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------
  // Scoreboard: everything sampled at the rising edge, in one process,
  // so a request and a result at the same edge are handled in order.
  // ---------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    pin_info_t      pin;
    sender_result_t e;
    int             base;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_WINDOW) win_size_reg = cfg_data[WS_BITS-1:0];
        else win_timeout_reg = cfg_data[TO_BITS-1:0];
      end
      if (in_tvalid && in_tready) begin
        pin = pinned_q[0];
        pinned_q.delete(0);
        base = pending_results.size();
        apply_request(in_tuser, in_tdata[31:0], in_tdata[47:32], in_tdata[48]);
        // typed rows replace the model's expectation with the table's
        if (pin.pinned) begin
          while (pending_results.size() > base)
            pending_results.delete(pending_results.size() - 1);
          pending_results.insert(pending_results.size(), pin.res);
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, event", out_tuser, 32'd0);
        end else begin
          e = pending_results[0];
          pending_results.delete(0);
          if (out_tuser !== e.ev)
            report_mismatch("event_res", out_tuser, e.ev);
          if (out_tdata[15:0] !== e.seq)
            report_mismatch("seq_number", out_tdata[15:0], e.seq);
          if (out_tdata[47:16] !== e.data)
            report_mismatch("data_out", out_tdata[47:16], e.data);
          if (out_tdata[52:48] !== e.cnt)
            report_mismatch("window_count", out_tdata[52:48], e.cnt);
          if (out_tdata[53] !== e.full)
            report_mismatch("window_full", out_tdata[53], e.full);
          if (out_tlast !== e.last)
            report_mismatch("last", out_tlast, e.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts.
  initial begin : sink_stall
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 6);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 10);
      end
      repeat (n) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------
  // Offer one request and hold it until the block takes it.
  task automatic issue_request(input logic [1:0] cmd, input logic [31:0] pay,
                               input logic [15:0] ack, input logic ok,
                               input bit pinned, input sender_result_t res);
    pin_info_t pin;
    pin.pinned = pinned;
    pin.res = res;
    pinned_q.insert(pinned_q.size(), pin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, ok, ack, pay};
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait for every pending result.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Both registers, back to back, while the block is idle.
  task automatic write_regs(input logic [15:0] ws, input logic [15:0] to);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_WINDOW;
    cfg_data <= ws;
    @(posedge clk);
    cfg_index <= CFG_IDX_TIMEOUT;
    cfg_data <= to;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t req_row(logic [1:0] cmd, logic [31:0] pay,
                                        logic [15:0] ack, logic ok);
    stim_row_t r;
    r = '{default: '0};
    r.cmd = cmd;
    r.pay = pay;
    r.ack = ack;
    r.ok = ok;
    return r;
  endfunction

  function automatic stim_row_t pinned_row(logic [1:0] cmd, logic [31:0] pay,
                                           logic [15:0] ack, logic ok, logic [2:0] ev,
                                           logic [15:0] seq, logic [31:0] data,
                                           logic [4:0] cnt, logic full);
    stim_row_t r;
    r = req_row(cmd, pay, ack, ok);
    r.pinned = 1'b1;
    r.res = '{ev, seq, data, cnt, full, 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [15:0] ws, logic [15:0] to);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.ws_val = ws;
    r.to_val = to;
    return r;
  endfunction

  // Append one line to the directed table.
  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin : stimulus
    int             p, k, r;
    logic [1:0]     cmd;
    logic [31:0]    pay;
    logic [15:0]    ack;
    logic           ok;
    stim_row_t      row;

    foreach (win_ring[i]) win_ring[i] = '0;

    // Directed table. Starts from reset: window 4, timeout 100.
    add_row(pinned_row(CMD_TICK, 0, 0, 1,         // timer not running
                       EV_IGNORED, 0, 0, 0, 0));
    add_row(pinned_row(CMD_ACK, 0, 16'hFFFF, 1,   // ack on empty window
                       EV_ACK_OK, 0, 0, 0, 0));
    add_row(pinned_row(CMD_ACK, 0, 16'hFFFF, 0,   // bad checksum
                       EV_ACK_BAD, 0, 0, 0, 0));
    add_row(pinned_row(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1,
                       EV_IGNORED, 0, 0, 0, 0));
    add_row(pinned_row(CMD_SEND, 32'hFFFF_FFFF, 0, 0,
                       EV_TX_NEW, 1, 32'hFFFF_FFFF, 1, 0));
    add_row(pinned_row(CMD_SEND, 32'h0, 0, 0,
                       EV_TX_NEW, 2, 32'h0, 2, 0));
    add_row(pinned_row(CMD_SEND, 32'hA5A5_A5A5, 0, 0,
                       EV_TX_NEW, 3, 32'hA5A5_A5A5, 3, 0));
    add_row(pinned_row(CMD_SEND, 32'h5A5A_5A5A, 0, 0,
                       EV_TX_NEW, 4, 32'h5A5A_5A5A, 4, 1));
    add_row(pinned_row(CMD_SEND, 32'h1, 0, 0,     // window full
                       EV_REFUSED, 0, 0, 4, 1));
    add_row(req_row(CMD_ACK, 0, 16'h0000, 1));    // stale: replay all 4
    add_row(pinned_row(CMD_ACK, 0, 16'd2, 1,      // frees 1 and 2
                       EV_ACK_OK, 0, 0, 2, 0));
    add_row(req_row(CMD_ACK, 0, 16'hFFFF, 1));    // stale across the wrap
    add_row(pinned_row(CMD_ACK, 0, 16'h8002, 0,
                       EV_ACK_BAD, 0, 0, 2, 0));
    add_row(pinned_row(CMD_TICK, 0, 0, 1,         // counts down only
                       EV_IGNORED, 0, 0, 2, 0));
    add_row(pinned_row(CMD_ACK, 0, 16'd4, 1,
                       EV_ACK_OK, 0, 0, 0, 0));
    add_row(pinned_row(CMD_ACK, 0, 16'h8003, 1,   // empty: no stale check
                       EV_ACK_OK, 0, 0, 0, 0));
    add_row(pinned_row(CMD_TICK, 0, 0, 1,
                       EV_IGNORED, 0, 0, 0, 0));
    add_row(cfg_row(16'd0, 16'd1));               // window 0 acts as 1
    add_row(pinned_row(CMD_SEND, 32'h1234_5678, 0, 0,
                       EV_TX_NEW, 5, 32'h1234_5678, 1, 1));
    add_row(pinned_row(CMD_SEND, 32'h0, 0, 0,
                       EV_REFUSED, 0, 0, 1, 1));
    add_row(pinned_row(CMD_TICK, 0, 0, 1,         // expiry, replay one
                       EV_RETX, 5, 32'h1234_5678, 1, 1));
    add_row(pinned_row(CMD_ACK, 0, 16'd5, 1,
                       EV_ACK_OK, 0, 0, 0, 0));
    add_row(pinned_row(CMD_TICK, 0, 0, 1,         // expiry on empty window
                       EV_IGNORED, 0, 0, 0, 0));
    add_row(pinned_row(CMD_TICK, 0, 0, 1,         // timer now stopped
                       EV_IGNORED, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_drain();
        write_regs(row.ws_val, row.to_val);
      end else begin
        issue_request(row.cmd, row.pay, row.ack, row.ok, row.pinned, row.res);
      end
    end

    // Random phases. Mostly sends and acks that land inside the window,
    // plus stale, random and corrupt acks, ticks and the unused code.
    for (p = 0; p < PHASES; p++) begin
      wait_drain();
      write_regs(16'(phase_ws[p]), 16'(phase_to[p]));
      if (p == PHASES - 1) quiet = 1'b1;
      for (k = 0; k < PHASE_REQS; k++) begin
        if (p == 1 && k == PHASE_REQS / 2) wait_drain();   // sender holds off mid-phase
        r = $urandom_range(0, 99);
        pay = $urandom;
        ack = $urandom;
        ok = 1'b1;
        if (r < 5) begin
          cmd = CMD_UNUSED;
          ok = $urandom_range(0, 1);
        end else if (r < 45) begin
          cmd = CMD_SEND;
          ok = $urandom_range(0, 1);
        end else if (r < 75) begin
          cmd = CMD_ACK;
          r = $urandom_range(0, 99);
          if (r < 55)
            ack = win_head_seq + 16'($urandom_range(0, win_count > 0 ? win_count - 1 : 0));
          else if (r < 70)
            ack = win_head_seq - 16'($urandom_range(1, 4));
          else if (r >= 85)
            ok = 1'b0;
        end else begin
          cmd = CMD_TICK;
          ok = $urandom_range(0, 1);
        end
        issue_request(cmd, pay, ack, ok, 1'b0, '0);
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);   // catch any stray result
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> go_back_n_sender_window_unit.f
rtl/core/gbns_pkg.sv
rtl/core/gbns_ram.sv
rtl/core/gbns_out_q.sv
rtl/core/go_back_n_sender_window_unit.sv
dv/testbench.sv
